>>> hdl/assert_macros.svh
// Assertion macros shared by the track sector extractor modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define FTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fts_pkg.sv
// Package for the track sector extractor: field widths, mark bytes,
// result kind codes, the result bundle type and the CRC and position helpers.
package fts_pkg;

  localparam int POSITION_WIDTH = 16;
  localparam int OFFSET_W = 17;
  localparam int LEN_W = 11;
  localparam int COUNT_W = 9;
  localparam int POS_CALC_W = OFFSET_W + 4;

  localparam logic [7:0] MARK_ID = 8'hFE;
  localparam logic [7:0] MARK_DATA = 8'hFB;
  localparam logic [7:0] MARK_DELETED = 8'hF8;
  localparam logic [7:0] SYNC_BYTE = 8'hA1;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [POS_CALC_W-1:0] POS_MAX = POS_CALC_W'((64'd1 << POSITION_WIDTH) - 64'd1);

  // Result kinds; the same code indexes the pending mask of a bundle.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;
  localparam logic [1:0] KIND_EOT = 2'd3;

  typedef struct packed {
    logic [3:0]         mask;
    logic [7:0]         data_byte;
    logic [7:0]         id_track;
    logic [7:0]         id_head;
    logic [7:0]         id_sector;
    logic [7:0]         id_size;
    logic [15:0]        id_crc;
    logic [15:0]        bit_position;
    logic [LEN_W-1:0]   sector_length;
    logic [COUNT_W-1:0] sector_count;
  } fts_bundle_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_ID_MARK =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_BYTE), SYNC_BYTE), SYNC_BYTE), MARK_ID);

  function automatic logic [15:0] pos_sat(input logic [OFFSET_W-1:0] offset);
    logic [POS_CALC_W-1:0] p;
    p = (POS_CALC_W'(offset) + POS_CALC_W'(1)) << 3;
    if (p > POS_MAX) begin
      p = POS_MAX;
    end
    return p[15:0];
  endfunction

  function automatic logic [LEN_W-1:0] sector_len(input logic [7:0] size_code);
    return LEN_W'(128) << size_code[1:0];
  endfunction

endpackage

>>> hdl/fts_in_if.sv
// Input channel of the track sector extractor: one raw track byte per item.
// Uses no package.
interface fts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] flux_byte;
  logic       end_of_track;

  modport source(output valid, output flux_byte, output end_of_track, input ready);
  modport sink(input valid, input flux_byte, input end_of_track, output ready);
endinterface

>>> hdl/fts_out_if.sv
// Result channel of the track sector extractor: one result per item.
// Depends on fts_pkg for the length and count widths.
interface fts_out_if
  import fts_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         data_byte;
  logic [7:0]         id_track;
  logic [7:0]         id_head;
  logic [7:0]         id_sector;
  logic [7:0]         id_size;
  logic [15:0]        id_crc;
  logic [15:0]        bit_position;
  logic [LEN_W-1:0]   sector_length;
  logic [COUNT_W-1:0] sector_count;
  logic               last;

  modport source(output valid, output kind, output data_byte, output id_track,
                 output id_head, output id_sector, output id_size, output id_crc,
                 output bit_position, output sector_length, output sector_count,
                 output last, input ready);
  modport sink(input valid, input kind, input data_byte, input id_track,
               input id_head, input id_sector, input id_size, input id_crc,
               input bit_position, input sector_length, input sector_count,
               input last, output ready);
endinterface

>>> hdl/fts_core.sv
// Track parsing state machine: mark hunting, ID capture with CRC, data count.
// Depends on fts_pkg, fts_in_if and assert_macros.svh.
`include "assert_macros.svh"

module fts_core
  import fts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fts_in_if.sink      in_ch,
  input  logic        can_load,
  output logic        load,
  output fts_bundle_t bnd
);

  localparam logic [1:0] PH_HUNT_ID = 2'd0;
  localparam logic [1:0] PH_ID = 2'd1;
  localparam logic [1:0] PH_HUNT_DATA = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0]          phase_r, phase_nxt;
  logic [7:0]          id_r [4];
  logic [7:0]          id_nxt [4];
  logic [1:0]          idx_r, idx_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [15:0]         pos_r, pos_nxt;
  logic [LEN_W-1:0]    left_r, left_nxt, left_dec;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [7:0]          b;
  logic                in_fire;

  assign in_ch.ready = can_load;
  assign in_fire = in_ch.valid && can_load;
  assign load = in_fire;
  assign b = in_ch.flux_byte;
  assign left_dec = (left_r != '0) ? (left_r - LEN_W'(1)) : left_r;

  always_comb begin
    phase_nxt = phase_r;
    id_nxt = id_r;
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    left_nxt = left_r;
    count_nxt = count_r;
    bnd = '0;

    unique case (phase_r)
      PH_HUNT_ID: begin
        if (b == MARK_ID) begin
          pos_nxt = pos_sat(offset_r);
          crc_nxt = CRC_ID_MARK;
          idx_nxt = '0;
          phase_nxt = PH_ID;
        end
      end
      PH_ID: begin
        id_nxt[idx_r] = b;
        crc_nxt = crc_byte(crc_r, b);
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          phase_nxt = PH_HUNT_DATA;
        end
      end
      PH_HUNT_DATA: begin
        if (b == MARK_DATA || b == MARK_DELETED) begin
          left_nxt = sector_len(id_r[3]);
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        bnd.mask[KIND_DATA] = 1'b1;
        bnd.data_byte = b;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          bnd.mask[KIND_DONE] = 1'b1;
          bnd.id_track = id_r[0];
          bnd.id_head = id_r[1];
          bnd.id_sector = id_r[2];
          bnd.id_size = id_r[3];
          bnd.id_crc = crc_r;
          bnd.bit_position = pos_r;
          bnd.sector_length = sector_len(id_r[3]);
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + COUNT_W'(1);
          end
          phase_nxt = PH_HUNT_ID;
        end
      end
    endcase

    offset_nxt = (offset_r != OFFSET_MAX) ? (offset_r + OFFSET_W'(1)) : offset_r;

    if (in_ch.end_of_track) begin
      if (phase_nxt == PH_DATA) begin
        bnd.mask[KIND_DISCARD] = 1'b1;
      end
      bnd.mask[KIND_EOT] = 1'b1;
      bnd.sector_count = count_nxt;
      phase_nxt = PH_HUNT_ID;
      id_nxt = '{default: '0};
      idx_nxt = '0;
      crc_nxt = '0;
      offset_nxt = '0;
      pos_nxt = '0;
      left_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_ID;
      id_r <= '{default: '0};
      idx_r <= '0;
      crc_r <= '0;
      offset_r <= '0;
      pos_r <= '0;
      left_r <= '0;
      count_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      id_r <= id_nxt;
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      offset_r <= offset_nxt;
      pos_r <= pos_nxt;
      left_r <= left_nxt;
      count_r <= count_nxt;
    end
  end

  `FTS_ASSERT_IMPL(a_data_left_nonzero, phase_r == PH_DATA, left_r != '0, "data phase with no bytes left")
  `FTS_ASSERT_NEXT(a_eot_clears, in_fire && in_ch.end_of_track, phase_r == PH_HUNT_ID && count_r == '0, "track end did not clear state")

endmodule

>>> hdl/fts_outq.sv
// Result register: holds one input item's results and hands them out one per cycle
// while ready, in kind order. Depends on fts_pkg, fts_out_if and assert_macros.svh.
`include "assert_macros.svh"

module fts_outq
  import fts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  fts_bundle_t bnd_in,
  output logic        can_load,
  fts_out_if.source   out_ch
);

  logic [3:0]  mask_r, mask_nxt, mask_rest;
  fts_bundle_t bnd_r;
  logic        pop;
  logic [1:0]  kind;

  assign mask_rest = mask_r & (mask_r - 4'd1);
  assign pop = out_ch.valid && out_ch.ready;
  assign can_load = (mask_rest == '0) && ((mask_r == '0) || out_ch.ready);

  always_comb begin
    priority if (mask_r[KIND_DATA]) begin
      kind = KIND_DATA;
    end else if (mask_r[KIND_DONE]) begin
      kind = KIND_DONE;
    end else if (mask_r[KIND_DISCARD]) begin
      kind = KIND_DISCARD;
    end else begin
      kind = KIND_EOT;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = bnd_in.mask;
    end else if (pop) begin
      mask_nxt = mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bnd_in;
    end
  end

  assign out_ch.valid = (mask_r != '0);
  assign out_ch.kind = kind;
  assign out_ch.last = (mask_rest == '0);
  assign out_ch.data_byte = (kind == KIND_DATA) ? bnd_r.data_byte : '0;
  assign out_ch.id_track = (kind == KIND_DONE) ? bnd_r.id_track : '0;
  assign out_ch.id_head = (kind == KIND_DONE) ? bnd_r.id_head : '0;
  assign out_ch.id_sector = (kind == KIND_DONE) ? bnd_r.id_sector : '0;
  assign out_ch.id_size = (kind == KIND_DONE) ? bnd_r.id_size : '0;
  assign out_ch.id_crc = (kind == KIND_DONE) ? bnd_r.id_crc : '0;
  assign out_ch.bit_position = (kind == KIND_DONE) ? bnd_r.bit_position : '0;
  assign out_ch.sector_length = (kind == KIND_DONE) ? bnd_r.sector_length : '0;
  assign out_ch.sector_count = (kind == KIND_EOT) ? bnd_r.sector_count : '0;

  `FTS_ASSERT_IMPL(a_multi_blocks_input, $countones(mask_r) > 1, !can_load, "new item taken over pending results")
  `FTS_ASSERT(a_done_excludes_discard, !(mask_r[KIND_DONE] && mask_r[KIND_DISCARD]), "sector both completed and discarded")

endmodule

>>> hdl/floppy_track_sector_extractor.sv
// Floppy track sector extractor. Takes one raw track byte per item and can
// accept a byte in every cycle unless held; the state update and the byte's
// results are both registered at the edge that takes the byte, so its first
// result is offered in the next cycle. A byte gives zero to three results
// (data byte, sector complete, discard marker, end of track), and the result
// register hands out a result in every ready cycle, so a byte that gives
// two or three results holds the input until its last result is taken; the
// sector-complete and track-end bytes are the only such cases. While the
// receiver stalls, the input is held as soon as one result waits.
// Depends on fts_pkg, fts_in_if, fts_out_if, fts_core and fts_outq.
module floppy_track_sector_extractor
  import fts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fts_in_if.sink    in_ch,
  fts_out_if.source out_ch
);

  fts_bundle_t bnd;
  logic        load;
  logic        can_load;

  fts_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .can_load (can_load),
    .load     (load),
    .bnd      (bnd)
  );

  fts_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .bnd_in   (bnd),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
